// ----- src/replay_counter_table_defines.svh -----
// assertion helpers for the rtl files (included by rct_datapath)
`ifndef REPLAY_COUNTER_TABLE_DEFINES_SVH
`define REPLAY_COUNTER_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rct_pkg.sv -----
package rct_pkg;

    // field widths
    localparam int SENDER_W    = 16;
    localparam int COUNT_W     = 32;
    localparam int ENTRY_W     = SENDER_W + COUNT_W;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // default table size
    localparam int SLOTS_DEF = 32;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_COMPARE,
        ST_WRITE,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic compare;
        logic write;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero_count;
        logic match;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- src/rct_ram.sv -----
module rct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rct_ctrl.sv -----
module rct_ctrl
    import rct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_START;
            end
            ST_START: begin
                if (i_status.zero_count) n_state = ST_FINISH;
                else                     n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (i_status.match || i_status.last) n_state = ST_WRITE;
                else                                 n_state = ST_READ;
            end
            ST_WRITE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_START: begin
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/rct_datapath.sv -----
`include "replay_counter_table_defines.svh"

module rct_datapath
    import rct_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SENDER_W-1:0]    i_sender,
    input  logic [COUNT_W-1:0]     i_msg_counter,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_accepted,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status
);

    localparam int IW = $clog2(SLOTS);

    logic [SENDER_W-1:0] r_sender;
    logic [COUNT_W-1:0]  r_count;
    logic                r_zero;
    logic [IW-1:0]       r_idx;
    logic                r_hit;
    logic                r_stale;
    logic [IW-1:0]       r_hit_idx;
    logic                r_free_found;
    logic [IW-1:0]       r_free_idx;
    logic [IW-1:0]       r_ptr;
    logic [SLOTS-1:0]    r_valid;
    logic                r_out_valid;
    logic                r_out_acc;

    logic [ENTRY_W-1:0]  rd_entry;
    logic [SENDER_W-1:0] rd_sender;
    logic [COUNT_W-1:0]  rd_highest;
    logic                match_now;
    logic                last_now;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic                accept_now;
    logic                use_victim;

    // entry layout: highest counter above sender id
    rct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({r_count, r_sender}),
        .i_re    (i_cmd.read),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    assign rd_sender  = rd_entry[SENDER_W-1:0];
    assign rd_highest = rd_entry[ENTRY_W-1:SENDER_W];

    // compare of the entry fetched in the previous cycle
    assign match_now = r_valid[r_idx] && (rd_sender == r_sender);
    assign last_now  = (r_idx == IW'(SLOTS - 1));

    // update target: hit entry, else first free, else round-robin victim
    assign use_victim = !r_hit && !r_free_found;
    assign wr_addr    = r_hit ? r_hit_idx : (r_free_found ? r_free_idx : r_ptr);
    assign wr_en      = i_cmd.write && !(r_hit && r_stale);
    assign accept_now = !r_zero && !(r_hit && r_stale);

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero       <= 1'b0;
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_stale      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_zero       <= (i_msg_counter == '0);
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_stale      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.compare) begin
            r_idx <= r_idx + IW'(1);
            if (match_now) begin
                r_hit   <= 1'b1;
                r_stale <= (r_count <= rd_highest);
            end else if (!r_valid[r_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sender <= i_sender;
            r_count  <= i_msg_counter;
        end
        if (i_cmd.compare && match_now) begin
            r_hit_idx <= r_idx;
        end
        if (i_cmd.compare && !match_now && !r_valid[r_idx] && !r_free_found) begin
            r_free_idx <= r_idx;
        end
    end

    // valid marks and round-robin pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.write && use_victim) begin
                r_ptr <= (r_ptr == IW'(SLOTS - 1)) ? '0 : r_ptr + IW'(1);
            end
        end
    end

    // output register, frees the controller while the result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_acc <= accept_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out_acc;

    always_comb begin
        o_status            = '0;
        o_status.zero_count = r_zero;
        o_status.match      = match_now;
        o_status.last       = last_now;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // victim replacement only happens with every entry in use
    `RCT_ASSERT_NOW(a_victim_full, i_clk, i_rst_n, i_cmd.write && use_victim, &r_valid, "victim replaced while a free entry exists")
    // a sender found in the scan stays in a valid entry
    `RCT_ASSERT_NOW(a_hit_valid, i_clk, i_rst_n, r_hit, r_valid[r_hit_idx], "hit entry is not valid")
    // a newly placed sender marks its entry valid
    `RCT_ASSERT_NEXT(a_new_valid, i_clk, i_rst_n, i_cmd.write && !r_hit, r_valid[$past(wr_addr)], "new entry not marked valid")

endmodule

// ----- src/replay_counter_table.sv -----
// replay_counter_table: per-sender anti-replay check
// slave channel carries a sender id and a message counter; the master channel
// returns one flag per item, set when the message is fresh and was recorded.
// a zero counter or a counter not above the stored one for a known sender is
// refused and leaves the table untouched; an unknown sender takes the lowest
// free entry, or a round-robin victim once the table is full.
// scan: the entries are fetched one at a time from a table ram with one read
// port, each by a read state and then a compare state; the scan stops at the
// first hit. a zero counter skips the scan and goes straight to the result.
// s_axis_tready rises in the same cycle as the result register is loaded.
// s_axis_tready is high only while no item is in work; one item at a time.
// a finished result sits in an output register, so the next item can be
// taken while the previous result waits; a stalled receiver holds the block
// only when a second result is ready before the first has been taken.
// reset (synchronous, active low) clears all valid marks and the round-robin
// pointer; there is no clearing pass.
module replay_counter_table
    import rct_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sender[15:0], msg_counter[47:16]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // accepted[0], zero fill above
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       accepted;

    rct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rct_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sender      (s_axis_tdata[SENDER_W-1:0]),
        .i_msg_counter (s_axis_tdata[ENTRY_W-1:SENDER_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_accepted    (accepted),
        .i_cmd         (cmd),
        .o_status      (status)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 1){1'b0}}, accepted};

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import rct_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 2 * SLOTS_DEF + 8;
    localparam int PHASE_ITEMS    = 190;
    localparam int POOL_MAX       = 128;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // sender[15:0], msg_counter[47:16]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // accepted[0], zero fill above

    // directed stimulus row
    typedef struct packed {
        logic [SENDER_W-1:0] sender;
        logic [COUNT_W-1:0]  count;
        logic                typed;
        logic                accepted;
    } t_dir_row;

    // model of the counter table
    bit                  tbl_valid   [SLOTS_DEF];
    logic [SENDER_W-1:0] tbl_sender  [SLOTS_DEF];
    logic [COUNT_W-1:0]  tbl_highest [SLOTS_DEF];
    int                  victim_ptr;

    bit verdict_q[$];
    int mismatch_cnt;
    int idle_cycles;
    int hold_requests;
    int burst_left;
    bit steady;

    replay_counter_table #(
        .SLOTS(SLOTS_DEF)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // table state after reset
    function automatic void clear_table();
        for (int i = 0; i < SLOTS_DEF; i++) begin
            tbl_valid[i]   = 1'b0;
            tbl_sender[i]  = '0;
            tbl_highest[i] = '0;
        end
        victim_ptr = 0;
    endfunction

    // freshness decision with table update
    function automatic bit judge_message(logic [SENDER_W-1:0] who, logic [COUNT_W-1:0] count);
        if (count == '0)
            return 1'b0;
        // lookup: lowest-numbered matching entry wins
        for (int i = 0; i < SLOTS_DEF; i++) begin
            if (tbl_valid[i] && tbl_sender[i] == who) begin
                if (count <= tbl_highest[i])
                    return 1'b0;
                tbl_highest[i] = count;
                return 1'b1;
            end
        end
        // unknown sender takes the lowest free entry
        for (int i = 0; i < SLOTS_DEF; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i]   = 1'b1;
                tbl_sender[i]  = who;
                tbl_highest[i] = count;
                return 1'b1;
            end
        end
        // table full: overwrite the round-robin victim
        tbl_sender[victim_ptr]  = who;
        tbl_highest[victim_ptr] = count;
        victim_ptr = (victim_ptr + 1) % SLOTS_DEF;
        return 1'b1;
    endfunction

    // offer one message and record the verdict at its transfer
    task automatic offer(logic [SENDER_W-1:0] who, logic [COUNT_W-1:0] count,
                         bit typed, bit typed_val);
        bit fresh;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, who};
        do @(posedge i_clk); while (!s_axis_tready);
        fresh = judge_message(who, count);
        verdict_q.push_back(typed ? typed_val : fresh);
    endtask

    // bursts with random gaps between them, none while steady is set
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering until every verdict has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: stall patterns, plus a long hold on request
    initial begin
        int mode;
        int mode_left;
        int rx_tick;
        int holds_served;
        mode = 0;
        mode_left = 0;
        rx_tick = 0;
        holds_served = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                rx_tick++;
                case (mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_axis_tready <= (rx_tick % 4 != 3);
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(0, 4) == 0);
                    end
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: accepted=%0b", m_axis_tdata[0]);
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("accepted mismatch: expected %0b, got %0b",
                                 want, m_axis_tdata[0]);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_dir_row            dir_rows [16];
        logic [SENDER_W-1:0] pool_id  [POOL_MAX];
        logic [COUNT_W-1:0]  pool_hint[POOL_MAX];
        int                  pool_sizes[7];
        int                  pool_n;
        int                  idx;
        int                  pick;
        logic [COUNT_W:0]    sum;
        logic [COUNT_W-1:0]  delta;
        logic [SENDER_W-1:0] who;
        logic [COUNT_W-1:0]  count;

        hold_requests = 0;
        burst_left    = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        clear_table();

        // sender, counter, typed, accepted
        dir_rows = '{
            '{16'h0000, 32'h0000_0000, 1'b1, 1'b0},  // zero counter, empty table
            '{16'h0000, 32'h0000_0001, 1'b1, 1'b1},  // new sender, free entry
            '{16'h0000, 32'h0000_0001, 1'b1, 1'b0},  // exact replay
            '{16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b1},  // jump to the top
            '{16'h0000, 32'hFFFF_FFFE, 1'b1, 1'b0},  // stale
            '{16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0},  // replay at the top
            '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},  // top sender, top counter
            '{16'hFFFF, 32'h0000_0000, 1'b1, 1'b0},  // zero counter, known sender
            '{16'hAAAA, 32'h5555_5555, 1'b1, 1'b1},
            '{16'h5555, 32'hAAAA_AAAA, 1'b1, 1'b1},
            '{16'hAAAA, 32'h5555_5556, 1'b1, 1'b1},  // one above stored
            '{16'h5555, 32'h8000_0000, 1'b1, 1'b0},  // below stored
            '{16'h8000, 32'h8000_0000, 1'b1, 1'b1},
            '{16'h0001, 32'h0001_0000, 1'b0, 1'b0},
            '{16'h0001, 32'h0000_FFFF, 1'b0, 1'b0},
            '{16'h0001, 32'h0001_0001, 1'b0, 1'b0}
        };
        pool_sizes = '{8, 31, 32, 33, 48, 100, 64};

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[i]) begin
            offer(dir_rows[i].sender, dir_rows[i].count, dir_rows[i].typed,
                  dir_rows[i].accepted);
            pace();
        end

        // random part: per-phase sender pools, mostly rising counters
        for (int p = 0; p < 7; p++) begin
            drain();
            steady = (p == 2 || p == 3);
            pool_n = pool_sizes[p];
            for (int i = 0; i < pool_n; i++) begin
                pool_id[i]   = (p == 1) ? SENDER_W'($urandom_range(0, 63))
                                        : SENDER_W'($urandom_range(0, 65535));
                pool_hint[i] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00
                                                           : COUNT_W'($urandom_range(0, 1000));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold while the sender keeps offering
                if (p == 3 && n == 50)
                    hold_requests++;
                idx  = $urandom_range(0, pool_n - 1);
                pick = $urandom_range(0, 99);
                who  = pool_id[idx];
                if (pick < 60) begin
                    // fresh counter, saturating at the top
                    delta = COUNT_W'($urandom_range(1, 1 << $urandom_range(0, 20)));
                    sum   = {1'b0, pool_hint[idx]} + {1'b0, delta};
                    count = sum[COUNT_W] ? 32'hFFFF_FFFF : sum[COUNT_W-1:0];
                    pool_hint[idx] = count;
                end else if (pick < 72) begin
                    count = pool_hint[idx];
                end else if (pick < 80) begin
                    count = (pool_hint[idx] > 1) ? COUNT_W'($urandom_range(1, pool_hint[idx] - 1))
                                                 : pool_hint[idx];
                end else if (pick < 85) begin
                    count = '0;
                end else if (pick < 93) begin
                    count = $urandom;
                    pool_hint[idx] = count;
                end else begin
                    // noise: any sender, any counter
                    who   = SENDER_W'($urandom_range(0, 65535));
                    count = $urandom;
                end
                offer(who, count, 1'b0, 1'b0);
                pace();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && verdict_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/rct_pkg.sv
src/rct_ram.sv
src/rct_ctrl.sv
src/rct_datapath.sv
src/replay_counter_table.sv
verif/tb_top.sv
